@@ rtl/kvf_pkg.sv @@
// Shared types and constants for the Kalman velocity fusion block.
// Used by the register file, the filter lanes and the top level.
package kvf_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 40;
    localparam int VAR_WIDTH_DEF = 40;
    localparam int APB_AW        = 6;
    localparam int APB_DW        = 64;
    localparam int MUL_W         = 34;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int DIV_STEPS     = 32;

    localparam logic [31:0]      RST_TIME_STEP    = 32'd4294967;
    localparam logic [CFG_W-1:0] RST_PVAR_LIN     = 40'd281475;
    localparam logic [CFG_W-1:0] RST_PVAR_ROT     = 40'd7036874;
    localparam logic [CFG_W-1:0] RST_MVAR_X       = 40'd28147498;
    localparam logic [CFG_W-1:0] RST_MVAR_Y       = 40'd28147498;
    localparam logic [CFG_W-1:0] RST_MVAR_ROT     = 40'd281475;

    localparam logic [32:0]       GAIN_ONE   = 33'h1_0000_0000;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h8000_0000);

    typedef enum logic [2:0] {
        REG_TIME_STEP = 3'd0,
        REG_PVAR_LIN  = 3'd1,
        REG_PVAR_ROT  = 3'd2,
        REG_MVAR_X    = 3'd3,
        REG_MVAR_Y    = 3'd4,
        REG_MVAR_ROT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]      time_step;
        logic [CFG_W-1:0] pvar_lin;
        logic [CFG_W-1:0] pvar_rot;
        logic [CFG_W-1:0] mvar_x;
        logic [CFG_W-1:0] mvar_y;
        logic [CFG_W-1:0] mvar_rot;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

    typedef enum logic [3:0] {
        LS_IDLE,
        LS_PRED,
        LS_XH,
        LS_DIV,
        LS_CMUL,
        LS_CORR,
        LS_VHI,
        LS_VLO,
        LS_DONE
    } t_lane_state;

    typedef enum logic [1:0] {
        MUL_PRED,
        MUL_CORR,
        MUL_VHI,
        MUL_VLO
    } t_mul_sel;

endpackage

@@ rtl/kvf_regs.sv @@
// APB configuration registers: sample period, process and measurement variances.
// Depends on kvf_pkg for register codes, reset values and the t_cfg struct.
module kvf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kvf_pkg::APB_AW-1:0]   paddr,
    input  logic [kvf_pkg::APB_DW-1:0]   pwdata,
    output logic [kvf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output kvf_pkg::t_cfg                o_cfg
);
    import kvf_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step <= RST_TIME_STEP;
            r_cfg.pvar_lin  <= RST_PVAR_LIN;
            r_cfg.pvar_rot  <= RST_PVAR_ROT;
            r_cfg.mvar_x    <= RST_MVAR_X;
            r_cfg.mvar_y    <= RST_MVAR_Y;
            r_cfg.mvar_rot  <= RST_MVAR_ROT;
        end else if (wr_en) begin
            unique case (idx)
                REG_TIME_STEP: r_cfg.time_step <= pwdata[31:0];
                REG_PVAR_LIN:  r_cfg.pvar_lin  <= pwdata[CFG_W-1:0];
                REG_PVAR_ROT:  r_cfg.pvar_rot  <= pwdata[CFG_W-1:0];
                REG_MVAR_X:    r_cfg.mvar_x    <= pwdata[CFG_W-1:0];
                REG_MVAR_Y:    r_cfg.mvar_y    <= pwdata[CFG_W-1:0];
                REG_MVAR_ROT:  r_cfg.mvar_rot  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TIME_STEP: prdata = APB_DW'(r_cfg.time_step);
            REG_PVAR_LIN:  prdata = APB_DW'(r_cfg.pvar_lin);
            REG_PVAR_ROT:  prdata = APB_DW'(r_cfg.pvar_rot);
            REG_MVAR_X:    prdata = APB_DW'(r_cfg.mvar_x);
            REG_MVAR_Y:    prdata = APB_DW'(r_cfg.mvar_y);
            REG_MVAR_ROT:  prdata = APB_DW'(r_cfg.mvar_rot);
            default:       prdata = '0;
        endcase
    end

endmodule

@@ rtl/kvf_lane.sv @@
// One scalar Kalman filter lane: predict, gain by restoring division, correct.
// Depends on kvf_pkg; one shared 34x34 multiplier serves all products.
module kvf_lane #(
    parameter int VARIANCE_WIDTH = kvf_pkg::VAR_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kvf_pkg::t_lane_ctrl                i_ctrl,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_rate,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_meas,
    input  logic [31:0]                        i_dt,
    input  logic [kvf_pkg::CFG_W-1:0]          i_q,
    input  logic [kvf_pkg::CFG_W-1:0]          i_r,
    output logic signed [kvf_pkg::DATA_W-1:0]  o_est,
    output kvf_pkg::t_lane_stat                o_stat
);
    import kvf_pkg::*;

    localparam int VW = VARIANCE_WIDTH;
    localparam int SW = ((VW > CFG_W) ? VW : CFG_W) + 1;
    localparam logic [VW-1:0] VAR_MAX = '1;

    t_lane_state r_state, n_state;
    t_mul_sel    mul_sel;
    logic        mul_en;

    logic signed [31:0]       r_rate, r_meas, r_v, r_xh;
    logic [VW-1:0]            r_e, r_ph;
    logic signed [PROD_W-1:0] r_prod;
    logic [63:0]              r_d, r_rem, r_acc;
    logic [32:0]              r_g;
    logic [4:0]               r_cnt;

    logic [SW-1:0]            sum_pq;
    logic [VW-1:0]            ph_sat;
    logic [64:0]              p65, r65, s65;
    logic [63:0]              p_div, r_div, d_div;
    logic                     p_zero, p_ge;
    logic [64:0]              t_sh, t_sub;
    logic                     q_bit;
    logic [63:0]              rem_next;
    logic signed [PROD_W-1:0] pr_rnd;
    logic signed [36:0]       xsum;
    logic signed [31:0]       xh_sat;
    logic signed [32:0]       innov;
    logic [32:0]              mag;
    logic [33:0]              corr;
    logic signed [33:0]       vsum;
    logic signed [31:0]       v_new;
    logic [32:0]              c_gain;
    logic [63:0]              ph64;
    logic [63:0]              e_sum;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // predicted variance, saturated
    assign sum_pq = SW'(r_e) + SW'(i_q);
    assign ph_sat = (|sum_pq[SW-1:VW]) ? VAR_MAX : sum_pq[VW-1:0];

    // divider operands
    assign p65    = 65'(r_ph);
    assign r65    = 65'(i_r);
    assign s65    = p65 + r65;
    assign p_div  = s65[64] ? p65[64:1] : p65[63:0];
    assign r_div  = s65[64] ? r65[64:1] : r65[63:0];
    assign d_div  = p_div + r_div;
    assign p_zero = (r_ph == '0);
    assign p_ge   = (p_div >= d_div);

    assign t_sh     = {r_rem, 1'b0};
    assign q_bit    = (t_sh >= {1'b0, r_d});
    assign t_sub    = t_sh - {1'b0, r_d};
    assign rem_next = q_bit ? t_sub[63:0] : t_sh[63:0];

    // prediction: round rate*dt to Q16.16, add, saturate
    assign pr_rnd = r_prod + ROUND_HALF;
    assign xsum   = 37'(r_v) + 37'($signed(pr_rnd[PROD_W-1:32]));
    always_comb begin
        if (xsum > 37'sd2147483647)
            xh_sat = 32'sh7fff_ffff;
        else if (xsum < -37'sd2147483648)
            xh_sat = 32'sh8000_0000;
        else
            xh_sat = xsum[31:0];
    end

    // correction toward the measurement
    assign innov = 33'(r_meas) - 33'(r_xh);
    assign mag   = innov[32] ? 33'(-innov) : 33'(innov);
    assign corr  = 34'(pr_rnd[PROD_W-1:32]);
    assign vsum  = innov[32] ? (34'(r_xh) - $signed(corr)) : (34'(r_xh) + $signed(corr));
    assign v_new = (r_g == GAIN_ONE) ? r_meas : vsum[31:0];

    // variance update operands
    assign c_gain = GAIN_ONE - r_g;
    assign ph64   = 64'(r_ph);
    assign e_sum  = r_acc + {32'd0, r_prod[63:32]};

    always_comb begin
        case (mul_sel)
            MUL_PRED: begin
                mul_a = MUL_W'(r_rate);
                mul_b = $signed({2'b00, i_dt});
            end
            MUL_CORR: begin
                mul_a = $signed({1'b0, mag});
                mul_b = $signed({1'b0, r_g});
            end
            MUL_VHI: begin
                mul_a = $signed({2'b00, ph64[63:32]});
                mul_b = $signed({1'b0, c_gain});
            end
            default: begin
                mul_a = $signed({2'b00, ph64[31:0]});
                mul_b = $signed({1'b0, c_gain});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LS_IDLE: if (i_ctrl.start) n_state = LS_PRED;
            LS_PRED: n_state = LS_XH;
            LS_XH:   n_state = (p_zero || p_ge) ? LS_CMUL : LS_DIV;
            LS_DIV:  if (r_cnt == 5'(DIV_STEPS - 1)) n_state = LS_CMUL;
            LS_CMUL: n_state = LS_CORR;
            LS_CORR: n_state = LS_VHI;
            LS_VHI:  n_state = LS_VLO;
            LS_VLO:  n_state = LS_DONE;
            LS_DONE: if (i_ctrl.ack) n_state = LS_IDLE;
            default: n_state = LS_IDLE;
        endcase
    end

    always_comb begin
        mul_sel     = MUL_PRED;
        mul_en      = 1'b0;
        o_stat.idle = 1'b0;
        o_stat.done = 1'b0;
        unique case (r_state)
            LS_IDLE: o_stat.idle = 1'b1;
            LS_PRED: begin
                mul_sel = MUL_PRED;
                mul_en  = 1'b1;
            end
            LS_CMUL: begin
                mul_sel = MUL_CORR;
                mul_en  = 1'b1;
            end
            LS_CORR: begin
                mul_sel = MUL_VHI;
                mul_en  = 1'b1;
            end
            LS_VHI: begin
                mul_sel = MUL_VLO;
                mul_en  = 1'b1;
            end
            LS_DONE: o_stat.done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_v     <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                LS_CORR: r_v <= v_new;
                LS_VLO:  r_e <= e_sum[VW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (r_state)
            LS_IDLE: begin
                r_rate <= i_rate;
                r_meas <= i_meas;
            end
            LS_PRED: r_ph <= ph_sat;
            LS_XH: begin
                r_xh  <= xh_sat;
                r_d   <= d_div;
                r_rem <= p_div;
                r_cnt <= '0;
                r_g   <= (!p_zero && p_ge) ? GAIN_ONE : '0;
            end
            LS_DIV: begin
                r_rem <= rem_next;
                r_g   <= {r_g[31:0], q_bit};
                r_cnt <= r_cnt + 5'd1;
            end
            LS_VHI: r_acc <= r_prod[63:0];
            default: ;
        endcase
    end

    assign o_est = r_v;

endmodule

@@ rtl/axis_kalman_velocity_fusion_top.sv @@
// Velocity fusion of IMU and wheel odometry by three scalar Kalman filter lanes
// (x, y, yaw rate). An input beat is taken when all lanes are idle; each lane
// then runs prediction, divider setup, a 32-step radix-2 gain division,
// correction and variance update on one shared multiplier, then hands the
// result over and returns to idle; no new beat is taken before that. The
// gain division is the longest of these steps. When every lane has a gain
// of 0 or 1.0 the division is skipped.
// The fused result waits in an output register while the next beat is taken;
// lanes hold a finished result until that register is free. Registers sit on
// an APB port at byte address 8*i, 64-bit data, pready always high.
// Depends on kvf_pkg, kvf_regs and kvf_lane.
module axis_kalman_velocity_fusion_top #(
    parameter int VARIANCE_WIDTH = kvf_pkg::VAR_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kvf_pkg::APB_AW-1:0]         paddr,
    input  logic [kvf_pkg::APB_DW-1:0]         pwdata,
    output logic [kvf_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_accel_x,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_accel_y,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_gyro_z,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_wheel_vel_x,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_wheel_vel_y,
    input  logic signed [kvf_pkg::DATA_W-1:0]  i_wheel_rate,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [kvf_pkg::DATA_W-1:0]  o_est_vel_x,
    output logic signed [kvf_pkg::DATA_W-1:0]  o_est_vel_y,
    output logic signed [kvf_pkg::DATA_W-1:0]  o_est_rate
);
    import kvf_pkg::*;

    t_cfg               cfg;
    t_lane_ctrl         lane_ctrl;
    t_lane_stat         stat_x, stat_y, stat_r;
    logic signed [31:0] est_x, est_y, est_r;
    logic               lanes_idle, lanes_done;
    logic               r_out_valid;
    logic signed [31:0] r_est_x, r_est_y, r_est_r;

    kvf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kvf_lane #(.VARIANCE_WIDTH(VARIANCE_WIDTH)) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_rate  (i_accel_x),
        .i_meas  (i_wheel_vel_x),
        .i_dt    (cfg.time_step),
        .i_q     (cfg.pvar_lin),
        .i_r     (cfg.mvar_x),
        .o_est   (est_x),
        .o_stat  (stat_x)
    );

    kvf_lane #(.VARIANCE_WIDTH(VARIANCE_WIDTH)) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_rate  (i_accel_y),
        .i_meas  (i_wheel_vel_y),
        .i_dt    (cfg.time_step),
        .i_q     (cfg.pvar_lin),
        .i_r     (cfg.mvar_y),
        .o_est   (est_y),
        .o_stat  (stat_y)
    );

    kvf_lane #(.VARIANCE_WIDTH(VARIANCE_WIDTH)) u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_rate  (i_gyro_z),
        .i_meas  (i_wheel_rate),
        .i_dt    (cfg.time_step),
        .i_q     (cfg.pvar_rot),
        .i_r     (cfg.mvar_rot),
        .o_est   (est_r),
        .o_stat  (stat_r)
    );

    assign lanes_idle      = stat_x.idle & stat_y.idle & stat_r.idle;
    assign lanes_done      = stat_x.done & stat_y.done & stat_r.done;
    assign o_ready         = lanes_idle;
    assign lane_ctrl.start = i_valid & lanes_idle;
    assign lane_ctrl.ack   = lanes_done & (~r_out_valid | i_ready);

    // merge the three lane results into one output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (lane_ctrl.ack) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctrl.ack) begin
            r_est_x <= est_x;
            r_est_y <= est_y;
            r_est_r <= est_r;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_est_vel_x = r_est_x;
    assign o_est_vel_y = r_est_y;
    assign o_est_rate  = r_est_r;

endmodule

@@ rtl/kvf_checker.sv @@
// Port-level checks for the Kalman velocity fusion top level, and its bind.
// Depends only on the top level's ports.
module kvf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_est_vel_x,
    input logic [31:0] o_est_vel_y,
    input logic [31:0] o_est_rate
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_est_vel_x) && $stable(o_est_vel_y)
                                && $stable(o_est_rate))
        else $error("output payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again while lanes busy");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared one cycle after input beat");

endmodule

bind axis_kalman_velocity_fusion_top kvf_checker u_kvf_checker (.*);
